### rtl/core/cdst_pkg.sv
// shared types and constants for the deferred send table
package cdst_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [7:0] GAIN_RESET = 8'd75;
	localparam logic [15:0] COOL_MAX = 16'hffff;
	localparam int RAD_W = 40;
	localparam int ROOT_W = 20;
	localparam int ROOT_STEPS = 20;

	typedef enum logic [1:0] {
		CMD_DISPATCH = 2'd0,
		CMD_TICK     = 2'd1,
		CMD_REMOVE   = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        source_valid;
		logic [15:0] source_id;
		logic [31:0] packet_handle;
		logic [23:0] distance;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [31:0] sent_packet;
		logic [15:0] sent_source;
		logic        last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_ROOT,
		ST_COOL,
		ST_SEARCH,
		ST_PLACE,
		ST_DIRECT,
		ST_FLUSH,
		ST_REMOVE,
		ST_EMIT_WAIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic root_step;
		logic cool;
		logic place_hit;
		logic place_append;
		logic emit_direct;
		logic scan_reset;
		logic scan_next;
		logic drop_cur;
		logic emit_cur;
		logic emit_last;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       source_valid;
		logic       scan_done;
		logic       cur_match;
		logic       cur_expired;
		logic       full;
		logic       out_busy;
		logic       pending;
	} sts_t;

endpackage

### rtl/core/cdst_datapath.sv
// table storage, delay arithmetic, scan pointer and output register
module cdst_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  cdst_pkg::in_item_t in_item,
	input  logic [7:0]        gain,
	input  cdst_pkg::ctl_t    ctl,
	output cdst_pkg::sts_t    sts,
	output logic              out_valid,
	output cdst_pkg::out_item_t out_item,
	input  logic              out_stall
);
	import cdst_pkg::*;

	in_item_t item_q;
	logic [15:0] src_q [TABLE_DEPTH];
	logic [31:0] pkt_q [TABLE_DEPTH];
	logic [31:0] dl_q [TABLE_DEPTH];
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] ptr_q;
	logic [15:0] gg_q;
	logic [RAD_W-1:0] rad_q;
	logic [RAD_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [31:0] dl_new_q;
	logic out_valid_q;
	out_item_t out_q;
	out_item_t stg_q;
	logic pend_q;

	logic [IDX_W-1:0] cur;
	logic [RAD_W+1:0] trial;
	logic [RAD_W-1:0] nrem;
	logic [1:0] pair;
	logic [15:0] s;
	logic [31:0] age;
	logic [16:0] coolw;
	logic emit_any;
	out_item_t new_beat;

	assign cur = ptr_q[IDX_W-1:0];
	// restoring square root, one result bit per step
	assign pair = rad_q[RAD_W-1 -: 2];
	assign trial = {rem_q, pair} - {{(RAD_W-ROOT_W){1'b0}}, root_q, 2'b01};
	assign nrem = trial[RAD_W+1] ? {rem_q[RAD_W-3:0], pair} : trial[RAD_W-1:0];
	assign s = root_q[ROOT_W-1:4];
	assign coolw = ({1'b0, s} > {9'd0, gain}) ? {1'b0, s} - {9'd0, gain} : 17'd0;
	assign age = item_q.now_ms - dl_q[cur];

	assign sts.cmd = item_q.cmd;
	assign sts.source_valid = item_q.source_valid;
	assign sts.scan_done = ptr_q >= used_q;
	assign sts.cur_match = src_q[cur] == item_q.source_id;
	assign sts.cur_expired = !age[31];
	assign sts.full = used_q == CNT_W'(TABLE_DEPTH);
	assign sts.out_busy = out_valid_q && out_stall;
	assign sts.pending = pend_q;

	assign emit_any = ctl.emit_direct || ctl.emit_cur;

	always_comb begin
		if (ctl.emit_direct)
			new_beat = '{item_q.packet_handle,
				item_q.source_valid ? item_q.source_id : 16'd0, 1'b0};
		else
			new_beat = '{pkt_q[cur], src_q[cur], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (ctl.load) item_q <= in_item;
		if (ctl.mul1) gg_q <= gain * gain;
		if (ctl.mul2) begin
			rad_q <= gg_q * item_q.distance;
			rem_q <= '0;
			root_q <= '0;
		end
		if (ctl.root_step) begin
			rad_q <= rad_q << 2;
			rem_q <= nrem;
			root_q <= {root_q[ROOT_W-2:0], ~trial[RAD_W+1]};
		end
		if (ctl.cool)
			dl_new_q <= item_q.now_ms + (coolw[16] ? 32'(COOL_MAX) : 32'(coolw[15:0]));
		if (ctl.place_hit) begin
			pkt_q[cur] <= item_q.packet_handle;
			dl_q[cur] <= dl_new_q;
		end
		if (ctl.place_append) begin
			src_q[used_q[IDX_W-1:0]] <= item_q.source_id;
			pkt_q[used_q[IDX_W-1:0]] <= item_q.packet_handle;
			dl_q[used_q[IDX_W-1:0]] <= dl_new_q;
		end
		// close up behind the dropped entry
		if (ctl.drop_cur) begin
			for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
				if (IDX_W'(j) >= cur) begin
					src_q[j] <= src_q[j+1];
					pkt_q[j] <= pkt_q[j+1];
					dl_q[j] <= dl_q[j+1];
				end
			end
		end
		// newest beat waits in the stage until it is known whether it is the final one
		if (emit_any) stg_q <= new_beat;
		if (emit_any && pend_q) out_q <= stg_q;
		else if (ctl.emit_last) out_q <= '{stg_q.sent_packet, stg_q.sent_source, 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			ptr_q <= '0;
			out_valid_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (ctl.place_append) used_q <= used_q + 1'b1;
			else if (ctl.drop_cur) used_q <= used_q - 1'b1;
			if (ctl.scan_reset) ptr_q <= '0;
			else if (ctl.scan_next) ptr_q <= ptr_q + 1'b1;
			if ((emit_any && pend_q) || ctl.emit_last) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (emit_any) pend_q <= 1'b1;
			else if (ctl.emit_last) pend_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;
endmodule

### rtl/core/cdst_ctrl.sv
// sequencer: delay computation, table search, flush and remove passes
module cdst_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  cdst_pkg::sts_t sts,
	output cdst_pkg::ctl_t ctl,
	output logic           busy
);
	import cdst_pkg::*;

	state_t state_q, state_d;
	logic [4:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		ctl = '0;
		in_stall = 1'b1;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: begin
				ctl.scan_reset = 1'b1;
				unique case (cmd_t'(sts.cmd))
					CMD_DISPATCH: begin
						if (sts.source_valid) begin
							ctl.mul1 = 1'b1;
							state_d = ST_MUL2;
						end else state_d = ST_DIRECT;
					end
					CMD_TICK: state_d = ST_FLUSH;
					CMD_REMOVE: state_d = ST_REMOVE;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_MUL2: begin
				ctl.mul2 = 1'b1;
				cnt_d = '0;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				ctl.root_step = 1'b1;
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'(ROOT_STEPS - 1)) state_d = ST_COOL;
			end
			ST_COOL: begin
				ctl.cool = 1'b1;
				state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (sts.scan_done) begin
					if (sts.full) state_d = ST_DIRECT;
					else begin
						ctl.place_append = 1'b1;
						ctl.scan_reset = 1'b1;
						state_d = ST_FLUSH;
					end
				end else if (sts.cur_match) begin
					ctl.place_hit = 1'b1;
					ctl.scan_reset = 1'b1;
					state_d = ST_FLUSH;
				end else ctl.scan_next = 1'b1;
			end
			ST_DIRECT: begin
				if (!sts.out_busy) begin
					ctl.emit_direct = 1'b1;
					ctl.scan_reset = 1'b1;
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (sts.scan_done) state_d = ST_EMIT_WAIT;
				else if (sts.cur_expired) begin
					if (!sts.out_busy) begin
						ctl.emit_cur = 1'b1;
						ctl.drop_cur = 1'b1;
					end
				end else ctl.scan_next = 1'b1;
			end
			ST_REMOVE: begin
				if (sts.scan_done) state_d = ST_IDLE;
				else if (sts.cur_match) ctl.drop_cur = 1'b1;
				else ctl.scan_next = 1'b1;
			end
			ST_EMIT_WAIT: begin
				// release the staged final beat with last set
				if (!sts.pending) state_d = ST_IDLE;
				else if (!sts.out_busy) begin
					ctl.emit_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### rtl/core/coalescing_deferred_send_table.sv
// top level of the coalescing deferred send table
// Input channel in_valid/in_stall carries one command beat (dispatch, tick,
// remove). Output channel out_valid/out_stall carries sent packets; the final
// beat of a command has last set. Config channel cfg_valid/cfg_ready writes
// delay_gain, taken only while the block is idle.
// One command is worked at a time; in_stall stays high from acceptance until
// the controller is idle again. A dispatch with a source runs the two
// multiplies, the 20-step square root and the deadline add, then searches
// the table for its source, flushes expired entries and releases the final
// beat. A dispatch without a source, or with no match and the table full,
// sends its packet directly and then flushes; a tick only flushes; a remove
// only drops the entries of its source.
// The table is searched and flushed through a single scan pointer.
// Each beat is staged until the next one is produced or the command ends, so
// the final beat can carry last; the output register then holds it while
// out_stall is high, and the flush waits on the current entry meanwhile.
// A command that sends nothing gives no beat.
// Reset empties the table and sets the gain to 75.
module coalescing_deferred_send_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  cdst_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output cdst_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);
	import cdst_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic busy;
	logic [7:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gain_q <= GAIN_RESET;
		else if (cfg_valid && cfg_ready) gain_q <= cfg_data;
	end

	assign cfg_ready = !busy;

	cdst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .ctl(ctl), .busy(busy)
	);

	cdst_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .gain(gain_q),
		.ctl(ctl), .sts(sts), .out_valid(out_valid), .out_item(out_item),
		.out_stall(out_stall)
	);

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !in_stall || busy)
		else $error("beat outside a command");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |-> !busy) else $error("config while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("stalled beat lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_item)) else $error("stalled beat changed");
endmodule
